// ===== hw/rtl/blat_pkg.sv =====
// ----------------------------------------------------------------------------
// blat_pkg
// Shared types and constants for the block level attenuation tracker.
// ----------------------------------------------------------------------------
package blat_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 15;
    localparam int LEVEL_W    = 15;
    localparam int COEF_W     = 16;
    localparam int COUNT_W    = 16;
    localparam int DIVISOR_W  = COUNT_W + 1;
    localparam int DB_SUM_W   = 27;
    localparam int CSUM_W     = 24;
    localparam int RATE_W     = 8;
    localparam int LOG_W      = 20;
    localparam int VALUE_W    = 46;
    localparam int DCNT_W     = 5;

    localparam logic [COUNT_W-1:0]  MAX_SUMMED_SAMPLES = COUNT_W'(4095);
    localparam logic [RATE_W-1:0]   RATE_RESET         = RATE_W'(20);
    localparam logic [18:0]         DB_PER_LOG2_Q16    = 19'd394568;
    localparam logic [14:0]         COEF_A             = 15'd16777;
    localparam logic [26:0]         COEF_B             = 27'd66571993;
    localparam logic [VALUE_W-1:0]  COEF_C             = VALUE_W'(989560465);
    localparam logic [DCNT_W-1:0]   DIV_LAST_STEP      = DCNT_W'(DB_SUM_W - 1);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    typedef struct packed {
        logic [MAG_W-1:0]     mag;
        logic                 do_log;
        logic                 last;
        logic [DIVISOR_W-1:0] divisor;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_port_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LNORM,
        ST_LSQ,
        ST_LMUL,
        ST_LACC,
        ST_DSTART,
        ST_MDIV,
        ST_MCLAMP,
        ST_C1,
        ST_C2,
        ST_C3,
        ST_C4,
        ST_UPD,
        ST_CDIV,
        ST_CSET,
        ST_OUT
    } back_state_t;

endpackage

// ===== hw/rtl/blat_queue.sv =====
// ----------------------------------------------------------------------------
// blat_queue
// Small register queue between the front classifier and the back datapath.
// ----------------------------------------------------------------------------
module blat_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  blat_pkg::q_port_t  push,
    output logic               full,
    output blat_pkg::q_port_t  head,
    input  logic               pop
);

    blat_pkg::q_entry_t           mem_reg [blat_pkg::QDEPTH];
    logic [blat_pkg::QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [blat_pkg::QPTR_W:0]    count_reg;
    logic                         do_push, do_pop;

    assign full       = (count_reg == (blat_pkg::QPTR_W+1)'(blat_pkg::QDEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/blat_front.sv =====
// ----------------------------------------------------------------------------
// blat_front
// Accepts sample words, tracks the position in the block and classifies each
// sample for the back datapath.
// ----------------------------------------------------------------------------
module blat_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [blat_pkg::SAMPLE_W-1:0]     s_tdata,
    input  logic                              s_tlast,
    input  logic                              q_full,
    output blat_pkg::q_port_t                 push
);

    logic [blat_pkg::COUNT_W-1:0] seen_reg, seen_next;
    logic                         accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        push.valid         = accept;
        push.entry.mag     = s_tdata[blat_pkg::MAG_W-1:0];
        // Only positive samples within the summed part of the block add a level.
        push.entry.do_log  = (seen_reg < blat_pkg::MAX_SUMMED_SAMPLES)
                             && !s_tdata[blat_pkg::SAMPLE_W-1]
                             && (s_tdata != '0);
        push.entry.last    = s_tlast;
        push.entry.divisor = {1'b0, seen_reg} + 1'b1;
        seen_next          = seen_reg;
        if (accept) begin
            if (s_tlast) begin
                seen_next = '0;
            end else if (seen_reg != '1) begin
                seen_next = seen_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
        end else begin
            seen_reg <= seen_next;
        end
    end

endmodule

// ===== hw/rtl/blat_back.sv =====
// ----------------------------------------------------------------------------
// blat_back
// Sequential datapath: log level, block mean, coefficient and averaging,
// with one shared restoring divider and an output register.
// ----------------------------------------------------------------------------
module blat_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [blat_pkg::RATE_W-1:0]   cfg_wdata,
    input  blat_pkg::q_port_t             head,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata
);

    blat_pkg::back_state_t state_reg, state_next;
    blat_pkg::q_entry_t    ent_reg, ent_next;

    logic [15:0]                        m_reg, m_next, frac_reg, frac_next;
    logic [3:0]                         e_reg, e_next, it_reg, it_next;
    logic [blat_pkg::LEVEL_W-1:0]       level_reg, level_next, mean_reg, mean_next;
    logic [blat_pkg::DB_SUM_W-1:0]      db_sum_reg, db_sum_next, quo_reg, quo_next;
    logic [blat_pkg::DIVISOR_W-1:0]     rem_reg, rem_next, den_reg, den_next;
    logic [blat_pkg::DCNT_W-1:0]        dcnt_reg, dcnt_next;
    logic [29:0]                        sq_reg, sq_next;
    logic [44:0]                        t_reg, t_next;
    logic [blat_pkg::VALUE_W-1:0]       v_reg, v_next;
    logic [blat_pkg::COEF_W-1:0]        coef_reg, coef_next, held_reg, held_next;
    logic [7:0]                         bc_reg, bc_next;
    logic [blat_pkg::CSUM_W-1:0]        csum_reg, csum_next;
    logic                               upd_reg, upd_next;
    logic [blat_pkg::RATE_W-1:0]        ab_reg, ab_next, rate;
    logic                               ov_reg, ov_next;
    logic [47:0]                        od_reg, od_next;

    logic [31:0]                        sq_prod;
    logic [16:0]                        m_sq;
    logic [39:0]                        lvl_prod;
    logic [blat_pkg::DB_SUM_W:0]        db_add;
    logic [blat_pkg::DIVISOR_W:0]       rs;
    logic                               div_done, do_update;
    logic [blat_pkg::VALUE_W-1:0]       v_round;
    logic [blat_pkg::CSUM_W:0]          csum_add;
    logic [3:0]                         e_norm;

    assign rate      = (ab_reg == '0) ? blat_pkg::RATE_W'(1) : ab_reg;
    assign div_done  = (dcnt_reg == blat_pkg::DIV_LAST_STEP);
    assign do_update = (bc_reg > rate) || (bc_reg == 8'hFF);
    assign m_tvalid  = ov_reg;
    assign m_tdata   = od_reg;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            blat_pkg::ST_IDLE: begin
                if (head.valid) begin
                    if (head.entry.do_log)    state_next = blat_pkg::ST_LNORM;
                    else if (head.entry.last) state_next = blat_pkg::ST_DSTART;
                end
            end
            blat_pkg::ST_LNORM:  state_next = blat_pkg::ST_LSQ;
            blat_pkg::ST_LSQ:    if (it_reg == 4'hF) state_next = blat_pkg::ST_LMUL;
            blat_pkg::ST_LMUL:   state_next = blat_pkg::ST_LACC;
            blat_pkg::ST_LACC:   state_next = ent_reg.last ? blat_pkg::ST_DSTART
                                                           : blat_pkg::ST_IDLE;
            blat_pkg::ST_DSTART: state_next = blat_pkg::ST_MDIV;
            blat_pkg::ST_MDIV:   if (div_done) state_next = blat_pkg::ST_MCLAMP;
            blat_pkg::ST_MCLAMP: state_next = blat_pkg::ST_C1;
            blat_pkg::ST_C1:     state_next = blat_pkg::ST_C2;
            blat_pkg::ST_C2:     state_next = blat_pkg::ST_C3;
            blat_pkg::ST_C3:     state_next = blat_pkg::ST_C4;
            blat_pkg::ST_C4:     state_next = blat_pkg::ST_UPD;
            blat_pkg::ST_UPD:    state_next = do_update ? blat_pkg::ST_CDIV
                                                        : blat_pkg::ST_OUT;
            blat_pkg::ST_CDIV:   if (div_done) state_next = blat_pkg::ST_CSET;
            blat_pkg::ST_CSET:   state_next = blat_pkg::ST_OUT;
            blat_pkg::ST_OUT:    if (!ov_reg || m_tready) state_next = blat_pkg::ST_IDLE;
            default:             state_next = blat_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output logic.
    always_comb begin
        ent_next   = ent_reg;
        m_next     = m_reg;
        frac_next  = frac_reg;
        e_next     = e_reg;
        it_next    = it_reg;
        level_next = level_reg;
        mean_next  = mean_reg;
        db_sum_next = db_sum_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        dcnt_next  = dcnt_reg;
        sq_next    = sq_reg;
        t_next     = t_reg;
        v_next     = v_reg;
        coef_next  = coef_reg;
        held_next  = held_reg;
        bc_next    = bc_reg;
        csum_next  = csum_reg;
        upd_next   = upd_reg;
        ab_next    = cfg_we ? cfg_wdata : ab_reg;
        ov_next    = ov_reg && !m_tready;
        od_next    = od_reg;
        pop        = 1'b0;

        e_norm = '0;
        for (int i = 0; i < blat_pkg::MAG_W; i++) begin
            if (ent_reg.mag[i]) e_norm = 4'(i);
        end
        sq_prod  = 32'(m_reg) * 32'(m_reg);
        m_sq     = sq_prod[31:15];
        lvl_prod = 40'({e_reg, frac_reg}) * 40'(blat_pkg::DB_PER_LOG2_Q16)
                   + 40'(1 << 23);
        db_add   = {1'b0, db_sum_reg} + (blat_pkg::DB_SUM_W+1)'(level_reg);
        rs       = {rem_reg, quo_reg[blat_pkg::DB_SUM_W-1]};
        v_round  = v_reg - blat_pkg::COEF_C + blat_pkg::VALUE_W'(1 << 27);
        csum_add = {1'b0, csum_reg} + (blat_pkg::CSUM_W+1)'(coef_reg);

        unique case (state_reg)
            blat_pkg::ST_IDLE: begin
                if (head.valid) begin
                    pop      = 1'b1;
                    ent_next = head.entry;
                end
            end
            blat_pkg::ST_LNORM: begin
                e_next    = e_norm;
                m_next    = 16'({1'b0, ent_reg.mag} << (4'd15 - e_norm));
                frac_next = '0;
                it_next   = '0;
            end
            blat_pkg::ST_LSQ: begin
                it_next = it_reg + 1'b1;
                if (m_sq[16]) begin
                    m_next    = m_sq[16:1];
                    frac_next = {frac_reg[14:0], 1'b1};
                end else begin
                    m_next    = m_sq[15:0];
                    frac_next = {frac_reg[14:0], 1'b0};
                end
            end
            blat_pkg::ST_LMUL: level_next = lvl_prod[38:24];
            blat_pkg::ST_LACC: begin
                db_sum_next = db_add[blat_pkg::DB_SUM_W] ? '1
                                                         : db_add[blat_pkg::DB_SUM_W-1:0];
            end
            blat_pkg::ST_DSTART: begin
                rem_next  = '0;
                quo_next  = db_sum_reg;
                den_next  = ent_reg.divisor;
                dcnt_next = '0;
            end
            blat_pkg::ST_MDIV, blat_pkg::ST_CDIV: begin
                dcnt_next = dcnt_reg + 1'b1;
                // One quotient bit per cycle; the remainder stays below the divisor.
                if (rs >= {1'b0, den_reg}) begin
                    rem_next = blat_pkg::DIVISOR_W'(rs - {1'b0, den_reg});
                    quo_next = {quo_reg[blat_pkg::DB_SUM_W-2:0], 1'b1};
                end else begin
                    rem_next = rs[blat_pkg::DIVISOR_W-1:0];
                    quo_next = {quo_reg[blat_pkg::DB_SUM_W-2:0], 1'b0};
                end
            end
            blat_pkg::ST_MCLAMP: begin
                mean_next   = (quo_reg > blat_pkg::DB_SUM_W'(32767)) ? '1
                                                                  : quo_reg[14:0];
                db_sum_next = '0;
            end
            blat_pkg::ST_C1: sq_next = 30'(mean_reg) * 30'(mean_reg);
            blat_pkg::ST_C2: t_next  = 45'(blat_pkg::COEF_A) * 45'(sq_reg);
            blat_pkg::ST_C3: begin
                v_next = {1'b0, t_reg}
                         + blat_pkg::VALUE_W'(42'(blat_pkg::COEF_B) * 42'(mean_reg));
            end
            blat_pkg::ST_C4: begin
                if (v_reg <= blat_pkg::COEF_C) begin
                    coef_next = '0;
                end else if (v_round[45:44] != '0) begin
                    coef_next = '1;
                end else begin
                    coef_next = v_round[43:28];
                end
            end
            blat_pkg::ST_UPD: begin
                if (do_update) begin
                    rem_next  = '0;
                    quo_next  = blat_pkg::DB_SUM_W'(csum_reg);
                    den_next  = blat_pkg::DIVISOR_W'(rate);
                    dcnt_next = '0;
                end else begin
                    bc_next   = bc_reg + 1'b1;
                    csum_next = csum_add[blat_pkg::CSUM_W] ? '1
                                                           : csum_add[blat_pkg::CSUM_W-1:0];
                    upd_next  = 1'b0;
                end
            end
            blat_pkg::ST_CSET: begin
                held_next = (quo_reg[blat_pkg::DB_SUM_W-1:16] != '0) ? '1 : quo_reg[15:0];
                bc_next   = 8'd1;
                csum_next = blat_pkg::CSUM_W'(coef_reg);
                upd_next  = 1'b1;
            end
            blat_pkg::ST_OUT: begin
                if (!ov_reg || m_tready) begin
                    ov_next = 1'b1;
                    od_next = {upd_reg, held_reg, coef_reg, mean_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        ent_reg   <= ent_next;
        m_reg     <= m_next;
        frac_reg  <= frac_next;
        e_reg     <= e_next;
        it_reg    <= it_next;
        level_reg <= level_next;
        mean_reg  <= mean_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        dcnt_reg  <= dcnt_next;
        sq_reg    <= sq_next;
        t_reg     <= t_next;
        v_reg     <= v_next;
        coef_reg  <= coef_next;
        upd_reg   <= upd_next;
        od_reg    <= od_next;
        if (!aresetn) begin
            state_reg  <= blat_pkg::ST_IDLE;
            db_sum_reg <= '0;
            held_reg   <= '0;
            bc_reg     <= '0;
            csum_reg   <= '0;
            ab_reg     <= blat_pkg::RATE_RESET;
            ov_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            db_sum_reg <= db_sum_next;
            held_reg   <= held_next;
            bc_reg     <= bc_next;
            csum_reg   <= csum_next;
            ab_reg     <= ab_next;
            ov_reg     <= ov_next;
        end
    end

endmodule

// ===== hw/rtl/block_level_attenuation_tracker.sv =====
// ----------------------------------------------------------------------------
// block_level_attenuation_tracker
// Mean block level in dB, mapped coefficient and averaged coefficient.
// ----------------------------------------------------------------------------
// A positive summed sample passes the log steps in the back datapath (normalise,
// squaring steps, multiply, accumulate); other non-final samples are only popped.
// A block-end word passes the mean division, clamp, coefficient steps and, on an
// update, the averaging division before it reaches the output register.
// Throughput is set by the log squaring (16 log steps) and the one-bit-per-cycle
// shared divider; a 4-entry queue buffers input words. Reset (aresetn low,
// synchronous) clears the sums, block and queue counters and sets the averaging register to 20.
module block_level_attenuation_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic        s_tlast,   // block_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [14:0] level_db, [30:15] block_coefficient,
                                   // [46:31] attenuation_coefficient,
                                   // [47] coefficient_updated
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata  // averaging_blocks
);

    blat_pkg::q_port_t push, head;
    logic              q_full, pop;

    blat_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push)
    );

    blat_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (q_full),
        .head    (head),
        .pop     (pop)
    );

    blat_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .head      (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
